/* rtl/core/cda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_pkg: calendar date arithmetic package
// Widths, operation codes, calendar tables and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cda_pkg;

   localparam int unsigned MAX_YEAR = 9999;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int NUM_W    = 23;   // day number from 0001-01-01
   localparam int OFFSET_W = NUM_W;
   localparam int CNT_W    = 6;    // repeats per stage, up to MAX_YEAR / 400
   localparam int CUM_W    = 9;
   localparam int MONTHS   = 12;

   // last day number that may be stored: MAX_YEAR-12-31
   localparam logic [NUM_W-1:0] DAY_TOP =
      NUM_W'(MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400 - 1);

   localparam logic [YEAR_W-1:0]  YEAR_LAST  = YEAR_W'(MAX_YEAR);
   localparam logic [MONTH_W-1:0] MONTH_LAST = MONTH_W'(MONTHS);

   // operation codes
   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_ADD     = 2'd1;
   localparam logic [1:0] OP_COMPARE = 2'd2;

   // decomposition stages: 400-year cycle, century, 4-year group, single year
   localparam logic [1:0] STG_CYCLE   = 2'd0;
   localparam logic [1:0] STG_CENTURY = 2'd1;
   localparam logic [1:0] STG_QUAD    = 2'd2;
   localparam logic [1:0] STG_YEAR    = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_YEARS,
      S_DATE,
      S_APPLY,
      S_MONTHS,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                       capture;
      logic                       set_error;
      logic                       start_years;
      logic                       start_days;
      logic                       step;
      logic                       stage_end;
      logic [1:0]                 stage;
      logic                       latch_num;
      logic                       commit_given;
      logic                       month_step;
      logic                       commit_date;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0]                 op;
      logic                       date_ok;
      logic                       add_ok;
      logic                       unit_fits;
      logic                       day_ok;
      logic                       month_fits;
   } dp_status_type;

   typedef struct packed {
      logic [1:0]                 op;
      logic [YEAR_W-1:0]          date_year;
      logic [MONTH_W-1:0]         date_month;
      logic [DAY_W-1:0]           date_day;
      logic signed [OFFSET_W-1:0] day_offset;
   } req_payload_type;

   typedef struct packed {
      logic [YEAR_W-1:0]          out_year;
      logic [MONTH_W-1:0]         out_month;
      logic [DAY_W-1:0]           out_day;
      logic                       is_less;
      logic                       is_equal;
      logic signed [OFFSET_W-1:0] day_difference;
      logic                       error;
   } rsp_payload_type;

   // years per stage unit
   function automatic logic [NUM_W-1:0] year_unit(input logic [1:0] stage);
      logic [NUM_W-1:0] u;
      unique case (stage)
         STG_CYCLE:   u = NUM_W'(400);
         STG_CENTURY: u = NUM_W'(100);
         STG_QUAD:    u = NUM_W'(4);
         STG_YEAR:    u = NUM_W'(1);
         default:     u = NUM_W'(1);
      endcase
      return u;
   endfunction

   // days per stage unit
   function automatic logic [NUM_W-1:0] day_unit(input logic [1:0] stage);
      logic [NUM_W-1:0] u;
      unique case (stage)
         STG_CYCLE:   u = NUM_W'(146097);
         STG_CENTURY: u = NUM_W'(36524);
         STG_QUAD:    u = NUM_W'(1461);
         STG_YEAR:    u = NUM_W'(365);
         default:     u = NUM_W'(365);
      endcase
      return u;
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] d;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = DAY_W'(31);
         4'd4, 4'd6, 4'd9, 4'd11:                    d = DAY_W'(30);
         4'd2:    d = leap ? DAY_W'(29) : DAY_W'(28);
         default: d = DAY_W'(0);
      endcase
      return d;
   endfunction

   // days in the year before the first of month m
   function automatic logic [CUM_W-1:0] days_before(input logic leap,
                                                    input logic [MONTH_W-1:0] m);
      logic [CUM_W-1:0] c;
      unique case (m)
         4'd1:    c = CUM_W'(0);
         4'd2:    c = CUM_W'(31);
         4'd3:    c = CUM_W'(59);
         4'd4:    c = CUM_W'(90);
         4'd5:    c = CUM_W'(120);
         4'd6:    c = CUM_W'(151);
         4'd7:    c = CUM_W'(181);
         4'd8:    c = CUM_W'(212);
         4'd9:    c = CUM_W'(243);
         4'd10:   c = CUM_W'(273);
         4'd11:   c = CUM_W'(304);
         4'd12:   c = CUM_W'(334);
         default: c = CUM_W'(0);
      endcase
      if (leap && m > 4'd2) begin
         c = c + CUM_W'(1);
      end
      return c;
   endfunction

endpackage

/* rtl/core/cda_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_if: request and response channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface cda_req_if;
   import cda_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [1:0]                 op;
   logic [YEAR_W-1:0]          date_year;
   logic [MONTH_W-1:0]         date_month;
   logic [DAY_W-1:0]           date_day;
   logic signed [OFFSET_W-1:0] day_offset;

   modport source (output valid, op, date_year, date_month, date_day, day_offset,
                   input ready);
   modport sink   (input valid, op, date_year, date_month, date_day, day_offset,
                   output ready);
endinterface

interface cda_rsp_if;
   import cda_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [YEAR_W-1:0]          out_year;
   logic [MONTH_W-1:0]         out_month;
   logic [DAY_W-1:0]           out_day;
   logic                       is_less;
   logic                       is_equal;
   logic signed [OFFSET_W-1:0] day_difference;
   logic                       error;

   modport source (output valid, out_year, out_month, out_day, is_less, is_equal,
                          day_difference, error,
                   input ready);
   modport sink   (input valid, out_year, out_month, out_day, is_less, is_equal,
                         day_difference, error,
                   output ready);
endinterface

/* rtl/core/calendar_date_arithmetic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_arithmetic: Gregorian date register with add and compare
// Top level: joins the sequencer and the datapath to the two channels.
// ----------------------------------------------------------------------------
// Usage
//   req_ch carries one operation per transfer: load a date, add a signed day
//   offset to the stored date, or compare the stored date with a given one.
//   rsp_ch returns exactly one response per request: the stored date after
//   the operation, less/equal flags, the signed difference in days and an
//   error flag. Invalid dates, results outside years 1 to MAX_YEAR and the
//   unused op code raise error and leave the stored date untouched.
//   One operation is in flight at a time; req_ch.ready is high only while the
//   block is idle. Unless it ends early on an error, an operation runs the
//   repeated-subtraction loop that splits years and day numbers into
//   400-year, 100-year, 4-year and 1-year units (at most 53 subtractions
//   and 4 stage changes); an add then steps through the months. A new
//   request is taken only after the response has been taken and the block
//   is idle again. A response is held on rsp_ch until the receiver takes it;
//   the block takes no new request meanwhile. Synchronous reset stores
//   0001-01-01 and returns the block to idle.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic
   import cda_pkg::*;
(
   input logic       clock,
   input logic       reset,
   cda_req_if.sink   req_ch,
   cda_rsp_if.source rsp_ch
);

   req_payload_type req_data;
   rsp_payload_type rsp_data;
   dp_cmd_type      cmd;
   dp_status_type   status;
   logic            req_ready;
   logic            rsp_valid;

   // gather the request fields for the datapath
   assign req_data.op         = req_ch.op;
   assign req_data.date_year  = req_ch.date_year;
   assign req_data.date_month = req_ch.date_month;
   assign req_data.date_day   = req_ch.date_day;
   assign req_data.day_offset = req_ch.day_offset;

   cda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cda_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // drive the channels; response fields come straight from registers
   assign req_ch.ready          = req_ready;
   assign rsp_ch.valid          = rsp_valid;
   assign rsp_ch.out_year       = rsp_data.out_year;
   assign rsp_ch.out_month      = rsp_data.out_month;
   assign rsp_ch.out_day        = rsp_data.out_day;
   assign rsp_ch.is_less        = rsp_data.is_less;
   assign rsp_ch.is_equal       = rsp_data.is_equal;
   assign rsp_ch.day_difference = rsp_data.day_difference;
   assign rsp_ch.error          = rsp_data.error;

endmodule

/* rtl/core/cda_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_datapath: date registers and day-number arithmetic
// Holds the stored date with its day number, and converts between years and
// day numbers by repeated subtraction of calendar units.
// ----------------------------------------------------------------------------
module cda_datapath
   import cda_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   input  dp_cmd_type      cmd,
   output dp_status_type   status,
   output rsp_payload_type rsp_data
);

   // captured request
   logic [1:0]                 op_ff;
   logic [YEAR_W-1:0]          gy_ff;
   logic [MONTH_W-1:0]         gm_ff;
   logic [DAY_W-1:0]           gd_ff;
   logic signed [OFFSET_W-1:0] off_ff;
   logic                       date_ok_ff;

   // stored date
   logic [YEAR_W-1:0]          cur_year_ff;
   logic [MONTH_W-1:0]         cur_month_ff;
   logic [DAY_W-1:0]           cur_day_ff;
   logic [NUM_W-1:0]           cur_num_ff;

   // conversion engine
   logic [NUM_W-1:0]           res_ff;
   logic [NUM_W-1:0]           acc_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [1:0]                 cen_ff;
   logic                       quad24_ff;
   logic [1:0]                 yr_ff;
   logic [NUM_W-1:0]           num_ff;
   logic [MONTH_W-1:0]         mon_ff;

   // result flags
   logic                       less_ff;
   logic                       equal_ff;
   logic signed [OFFSET_W-1:0] diff_ff;
   logic                       err_ff;

   logic                       day_mode;
   logic                       leap;
   logic [NUM_W-1:0]           sub_val;
   logic [NUM_W-1:0]           add_val;
   logic                       limited;
   logic [DAY_W-1:0]           dim_given;
   logic [DAY_W-1:0]           dim_cur;
   logic [NUM_W+1:0]           add_sum;
   logic [NUM_W:0]             diff_full;
   logic signed [OFFSET_W-1:0] diff_sat;
   logic [NUM_W-1:0]           num_in;
   logic                       year_ok;
   logic                       month_ok;

   assign day_mode = (op_ff == OP_ADD);
   // year is leap when it ends a 4-year group, unless it ends a century
   // that does not end a 400-year cycle
   assign leap     = (yr_ff == 2'd3) && (!quad24_ff || cen_ff == 2'd3);
   assign sub_val  = day_mode ? day_unit(cmd.stage)  : year_unit(cmd.stage);
   assign add_val  = day_mode ? year_unit(cmd.stage) : day_unit(cmd.stage);
   assign limited  = cmd.stage[0];
   assign dim_given = month_days(leap, gm_ff);
   assign dim_cur   = month_days(leap, mon_ff);

   assign add_sum   = {2'b00, cur_num_ff} + {{2{off_ff[OFFSET_W-1]}}, off_ff};
   assign diff_full = {1'b0, cur_num_ff} - {1'b0, num_ff};
   assign num_in    = acc_ff + NUM_W'(days_before(leap, gm_ff)) + NUM_W'(gd_ff)
                      - NUM_W'(1);

   // clamp to the width of the difference field
   always_comb begin
      priority if (!diff_full[NUM_W] && diff_full[NUM_W-1]) begin
         diff_sat = {1'b0, {(OFFSET_W-1){1'b1}}};
      end else if (diff_full[NUM_W] && !diff_full[NUM_W-1]) begin
         diff_sat = {1'b1, {(OFFSET_W-1){1'b0}}};
      end else begin
         diff_sat = diff_full[OFFSET_W-1:0];
      end
   end

   assign year_ok  = (req_data.date_year != '0) && (req_data.date_year <= YEAR_LAST);
   assign month_ok = (req_data.date_month != '0) && (req_data.date_month <= MONTH_LAST);

   assign status.op         = op_ff;
   assign status.date_ok    = date_ok_ff;
   assign status.add_ok     = !add_sum[NUM_W+1] && (add_sum[NUM_W:0] <= {1'b0, DAY_TOP});
   assign status.unit_fits  = (res_ff >= sub_val) && !(limited && cnt_ff == CNT_W'(3));
   assign status.day_ok     = (gd_ff != '0) && (gd_ff <= dim_given);
   assign status.month_fits = (mon_ff < MONTH_LAST) && (res_ff >= NUM_W'(dim_cur));

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_data.op;
         gy_ff      <= req_data.date_year;
         gm_ff      <= req_data.date_month;
         gd_ff      <= req_data.date_day;
         off_ff     <= req_data.day_offset;
         date_ok_ff <= year_ok && month_ok;
      end
   end

   // stored date, cleared to 0001-01-01
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_year_ff  <= YEAR_W'(1);
         cur_month_ff <= MONTH_W'(1);
         cur_day_ff   <= DAY_W'(1);
         cur_num_ff   <= '0;
      end else if (cmd.commit_given && op_ff == OP_LOAD) begin
         cur_year_ff  <= gy_ff;
         cur_month_ff <= gm_ff;
         cur_day_ff   <= gd_ff;
         cur_num_ff   <= num_ff;
      end else if (cmd.commit_date) begin
         cur_year_ff  <= acc_ff[YEAR_W-1:0] + YEAR_W'(1);
         cur_month_ff <= mon_ff;
         cur_day_ff   <= res_ff[DAY_W-1:0] + DAY_W'(1);
         cur_num_ff   <= num_ff;
      end
   end

   // conversion engine
   always_ff @(posedge clock) begin
      if (cmd.start_years) begin
         res_ff <= NUM_W'(gy_ff - YEAR_W'(1));
         acc_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.start_days) begin
         res_ff <= add_sum[NUM_W-1:0];
         num_ff <= add_sum[NUM_W-1:0];
         acc_ff <= '0;
         cnt_ff <= '0;
         mon_ff <= MONTH_W'(1);
      end else if (cmd.step) begin
         res_ff <= res_ff - sub_val;
         acc_ff <= acc_ff + add_val;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end else if (cmd.stage_end) begin
         cnt_ff <= '0;
         unique case (cmd.stage)
            STG_CENTURY: cen_ff    <= cnt_ff[1:0];
            STG_QUAD:    quad24_ff <= (cnt_ff == CNT_W'(24));
            STG_YEAR:    yr_ff     <= cnt_ff[1:0];
            default: ;
         endcase
      end else if (cmd.latch_num) begin
         num_ff <= num_in;
      end else if (cmd.month_step) begin
         res_ff <= res_ff - NUM_W'(dim_cur);
         mon_ff <= mon_ff + MONTH_W'(1);
      end
   end

   // result flags
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         less_ff  <= 1'b0;
         equal_ff <= 1'b0;
         diff_ff  <= '0;
         err_ff   <= 1'b0;
      end else if (cmd.set_error) begin
         err_ff   <= 1'b1;
      end else if (cmd.commit_given && op_ff == OP_COMPARE) begin
         less_ff  <= diff_full[NUM_W];
         equal_ff <= (diff_full == '0);
         diff_ff  <= diff_sat;
      end
   end

   assign rsp_data.out_year       = cur_year_ff;
   assign rsp_data.out_month      = cur_month_ff;
   assign rsp_data.out_day        = cur_day_ff;
   assign rsp_data.is_less        = less_ff;
   assign rsp_data.is_equal       = equal_ff;
   assign rsp_data.day_difference = diff_ff;
   assign rsp_data.error          = err_ff;

endmodule

/* rtl/core/cda_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_ctrl: operation sequencer
// Walks one operation through decode, year decomposition, date check and
// commit or month stepping, and response hand-off, issuing datapath commands.
// ----------------------------------------------------------------------------
module cda_ctrl
   import cda_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [1:0] stage_ff, stage_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stage_ff <= STG_CYCLE;
      end else begin
         state_ff <= state_in;
         stage_ff <= stage_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   always_comb begin
      state_in  = state_ff;
      stage_in  = stage_ff;
      cmd       = '0;
      cmd.stage = stage_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.op)
               OP_LOAD, OP_COMPARE: begin
                  if (status.date_ok) begin
                     cmd.start_years = 1'b1;
                     state_in        = S_YEARS;
                  end else begin
                     cmd.set_error = 1'b1;
                     state_in      = S_DONE;
                  end
               end
               OP_ADD: begin
                  if (status.add_ok) begin
                     cmd.start_days = 1'b1;
                     state_in       = S_YEARS;
                  end else begin
                     cmd.set_error = 1'b1;
                     state_in      = S_DONE;
                  end
               end
               default: begin
                  cmd.set_error = 1'b1;
                  state_in      = S_DONE;
               end
            endcase
         end
         S_YEARS: begin
            if (status.unit_fits) begin
               cmd.step = 1'b1;
            end else begin
               cmd.stage_end = 1'b1;
               if (stage_ff == STG_YEAR) begin
                  stage_in = STG_CYCLE;
                  state_in = (status.op == OP_ADD) ? S_MONTHS : S_DATE;
               end else begin
                  stage_in = stage_ff + 2'd1;
               end
            end
         end
         S_DATE: begin
            if (status.day_ok) begin
               cmd.latch_num = 1'b1;
               state_in      = S_APPLY;
            end else begin
               cmd.set_error = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_APPLY: begin
            cmd.commit_given = 1'b1;
            state_in         = S_DONE;
         end
         S_MONTHS: begin
            if (status.month_fits) begin
               cmd.month_step = 1'b1;
            end else begin
               cmd.commit_date = 1'b1;
               state_in        = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted request did not enter decode");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   a_stage_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECODE) |-> (stage_ff == STG_CYCLE))
      else $error("stage counter not cleared at start of operation");

   a_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready)
      else $error("block not idle after response transfer");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: calendar date arithmetic testbench
// Drives load, add and compare requests into calendar_date_arithmetic.
// A short table of corner cases runs first: calendar extremes, invalid dates,
// leap days, out-of-range adds and the unused op. Four phases of random
// requests follow, with different amounts of sender and receiver idling.
// A local calendar model predicts every response that the table does not
// give; each response is checked field by field, in order, against it.
// ----------------------------------------------------------------------------
module tb_top;
   import cda_pkg::*;

   // op code 3 has no meaning; the block must flag it
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int DIFF_HI = 4194303;
   localparam int DIFF_LO = -4194304;

   localparam int REQ_W = $bits(req_payload_type);

   // one row of the directed table; want is used only when typed is set
   typedef struct packed {
      req_payload_type req;
      logic            typed;
      rsp_payload_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cda_req_if req_bus ();
   cda_rsp_if rsp_bus ();

   calendar_date_arithmetic u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hard limit on the run
   initial begin
      #2_000_000;
      $display("calendar_date_arithmetic test failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Calendar model: the stored date and the rules that move it
   // -------------------------------------------------------------------------
   logic [YEAR_W-1:0]  cur_y;
   logic [MONTH_W-1:0] cur_m;
   logic [DAY_W-1:0]   cur_d;

   rsp_payload_type due_rsp [$];   // responses still owed by the block, oldest first
   int unsigned     fails = 0;
   int unsigned     idle_pct = 0;   // chance (per cent) that the sender sits out a cycle
   int unsigned     stall_pct = 0;  // chance (per cent) that the receiver holds off
   int              hold_left = 0;  // cycles left in a forced receiver hold-off

   function automatic bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned month_len(int unsigned y, int unsigned m);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap_year(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic bit date_valid(int unsigned y, int unsigned m, int unsigned d);
      return y >= 1 && y <= MAX_YEAR && m >= 1 && m <= MONTHS &&
             d >= 1 && d <= month_len(y, m);
   endfunction

   // days since 0001-01-01 of a valid date
   function automatic longint day_index(int unsigned y, int unsigned m, int unsigned d);
      longint      n;
      int unsigned py;
      py = y - 1;
      n = longint'(py) * 365 + py / 4 - py / 100 + py / 400;
      for (int unsigned k = 1; k < m; k++) n += month_len(y, k);
      return n + d - 1;
   endfunction

   // inverse of day_index: jump whole 400-year cycles, then walk years and months
   function automatic void index_to_date(longint n, output int unsigned y,
                                         output int unsigned m, output int unsigned d);
      longint      r;
      int unsigned len;
      r = n % 146097;
      y = 1 + 400 * int'(n / 146097);
      len = leap_year(y) ? 366 : 365;
      while (r >= len) begin
         r -= len;
         y++;
         len = leap_year(y) ? 366 : 365;
      end
      m = 1;
      while (r >= month_len(y, m)) begin
         r -= month_len(y, m);
         m++;
      end
      d = int'(r) + 1;
   endfunction

   // apply one request to the stored date and return the response it owes
   function automatic rsp_payload_type apply_date_op(req_payload_type p);
      rsp_payload_type r;
      longint          n;
      int unsigned     ny, nm, nd;
      r = '0;
      case (p.op)
         OP_LOAD: begin
            if (date_valid(p.date_year, p.date_month, p.date_day)) begin
               cur_y = p.date_year;
               cur_m = p.date_month;
               cur_d = p.date_day;
            end else begin
               r.error = 1'b1;
            end
         end
         OP_ADD: begin
            n = day_index(cur_y, cur_m, cur_d) + longint'($signed(p.day_offset));
            if (n < 0 || n > day_index(MAX_YEAR, MONTHS, 31)) begin
               r.error = 1'b1;
            end else begin
               index_to_date(n, ny, nm, nd);
               cur_y = YEAR_W'(ny);
               cur_m = MONTH_W'(nm);
               cur_d = DAY_W'(nd);
            end
         end
         OP_COMPARE: begin
            if (date_valid(p.date_year, p.date_month, p.date_day)) begin
               n = day_index(cur_y, cur_m, cur_d) -
                   day_index(p.date_year, p.date_month, p.date_day);
               r.is_less  = n < 0;
               r.is_equal = n == 0;
               if (n > DIFF_HI) n = DIFF_HI;
               if (n < DIFF_LO) n = DIFF_LO;
               r.day_difference = OFFSET_W'(n);
            end else begin
               r.error = 1'b1;
            end
         end
         default: r.error = 1'b1;
      endcase
      r.out_year  = cur_y;
      r.out_month = cur_m;
      r.out_day   = cur_d;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Random stimulus
   // -------------------------------------------------------------------------

   // pick a date; lean on the calendar's edges, centuries and month ends
   function automatic void pick_date(bit good, output logic [YEAR_W-1:0] y,
                                     output logic [MONTH_W-1:0] m,
                                     output logic [DAY_W-1:0] d);
      int unsigned yy, mm, len, roll;
      roll = $urandom_range(9);
      if (roll < 6)       yy = $urandom_range(MAX_YEAR, 1);
      else if (roll == 6) yy = $urandom_range(3, 1);
      else if (roll == 7) yy = $urandom_range(MAX_YEAR, MAX_YEAR - 2);
      else                yy = 100 * $urandom_range(MAX_YEAR / 100, 1);
      mm  = $urandom_range(MONTHS, 1);
      len = month_len(yy, mm);
      y = YEAR_W'(yy);
      m = MONTH_W'(mm);
      d = $urandom_range(1) ? DAY_W'(len - $urandom_range(1))
                            : DAY_W'($urandom_range(len, 1));
      if (!good) begin
         // break exactly one field
         case ($urandom_range(2))
            0: y = $urandom_range(1) ? '0
                     : YEAR_W'($urandom_range((1 << YEAR_W) - 1, MAX_YEAR + 1));
            1: m = $urandom_range(1) ? '0 : MONTH_W'($urandom_range(15, MONTHS + 1));
            default: d = (len == 31 || $urandom_range(1)) ? '0
                           : DAY_W'($urandom_range(31, len + 1));
         endcase
      end
   endfunction

   function automatic req_payload_type random_req();
      req_payload_type p;
      int unsigned     roll;
      int              off;
      // fill every field with noise first; the op decides which fields matter
      p = REQ_W'({$urandom, $urandom});
      roll = $urandom_range(99);
      if (roll < 30) begin
         p.op = OP_LOAD;
         pick_date(roll >= 3, p.date_year, p.date_month, p.date_day);
      end else if (roll < 65) begin
         p.op = OP_ADD;
         case ($urandom_range(9))
            0, 1, 2, 3: off = int'($urandom_range(800)) - 400;
            4, 5, 6:    off = int'($urandom_range(80000)) - 40000;
            7, 8:       off = int'($urandom_range(2 * DAY_TOP)) - int'(DAY_TOP);
            default:    off = int'($urandom);
         endcase
         p.day_offset = OFFSET_W'(off);
      end else if (roll < 95) begin
         p.op = OP_COMPARE;
         pick_date(roll >= 68, p.date_year, p.date_month, p.date_day);
         // now and then compare against the stored date itself
         if (roll >= 68 && $urandom_range(6) == 0) begin
            p.date_year  = cur_y;
            p.date_month = cur_m;
            p.date_day   = cur_d;
         end
      end else begin
         p.op = OP_UNUSED;
      end
      return p;
   endfunction

   // -------------------------------------------------------------------------
   // Directed table, run from the reset date 0001-01-01
   // -------------------------------------------------------------------------
   dir_row_type dir_rows [25] = '{
      // compare with the reset date itself
      '{'{OP_COMPARE, 14'd1, 4'd1, 5'd1, 23'sd0}, 1'b1,
        '{14'd1, 4'd1, 5'd1, 1'b0, 1'b1, 23'sd0, 1'b0}},
      // unused op
      '{'{OP_UNUSED, 14'd1, 4'd1, 5'd1, 23'sd0}, 1'b1,
        '{14'd1, 4'd1, 5'd1, 1'b0, 1'b0, 23'sd0, 1'b1}},
      // step back from the first day ever
      '{'{OP_ADD, 14'd0, 4'd0, 5'd0, OFFSET_W'(-1)}, 1'b1,
        '{14'd1, 4'd1, 5'd1, 1'b0, 1'b0, 23'sd0, 1'b1}},
      // last representable day
      '{'{OP_LOAD, YEAR_LAST, MONTH_LAST, 5'd31, 23'sd0}, 1'b1,
        '{YEAR_LAST, MONTH_LAST, 5'd31, 1'b0, 1'b0, 23'sd0, 1'b0}},
      '{'{OP_ADD, 14'd0, 4'd0, 5'd0, 23'sd1}, 1'b1,
        '{YEAR_LAST, MONTH_LAST, 5'd31, 1'b0, 1'b0, 23'sd0, 1'b1}},
      '{'{OP_COMPARE, 14'd1, 4'd1, 5'd1, 23'sd0}, 1'b1,
        '{YEAR_LAST, MONTH_LAST, 5'd31, 1'b0, 1'b0, DAY_TOP, 1'b0}},
      // full-span adds in both directions, then one day too far
      '{'{OP_LOAD, 14'd1, 4'd1, 5'd1, 23'sd0}, 1'b1,
        '{14'd1, 4'd1, 5'd1, 1'b0, 1'b0, 23'sd0, 1'b0}},
      '{'{OP_ADD, 14'd0, 4'd0, 5'd0, DAY_TOP}, 1'b1,
        '{YEAR_LAST, MONTH_LAST, 5'd31, 1'b0, 1'b0, 23'sd0, 1'b0}},
      '{'{OP_ADD, 14'd0, 4'd0, 5'd0, -DAY_TOP}, 1'b1,
        '{14'd1, 4'd1, 5'd1, 1'b0, 1'b0, 23'sd0, 1'b0}},
      '{'{OP_ADD, 14'd0, 4'd0, 5'd0, DAY_TOP + 1'b1}, 1'b1,
        '{14'd1, 4'd1, 5'd1, 1'b0, 1'b0, 23'sd0, 1'b1}},
      '{'{OP_COMPARE, YEAR_LAST, MONTH_LAST, 5'd31, 23'sd0}, 1'b1,
        '{14'd1, 4'd1, 5'd1, 1'b1, 1'b0, -DAY_TOP, 1'b0}},
      // invalid dates: month zero, month 13, year all ones, year zero,
      // 31 April, 29 February in a century year, day zero
      '{'{OP_LOAD, 14'd2000, 4'd0, 5'd10, 23'sd0}, 1'b1,
        '{14'd1, 4'd1, 5'd1, 1'b0, 1'b0, 23'sd0, 1'b1}},
      '{'{OP_LOAD, 14'd2000, 4'd13, 5'd10, 23'sd0}, 1'b1,
        '{14'd1, 4'd1, 5'd1, 1'b0, 1'b0, 23'sd0, 1'b1}},
      '{'{OP_LOAD, 14'h3fff, 4'd1, 5'd31, 23'sd0}, 1'b1,
        '{14'd1, 4'd1, 5'd1, 1'b0, 1'b0, 23'sd0, 1'b1}},
      '{'{OP_LOAD, 14'd0, 4'd6, 5'd15, 23'sd0}, 1'b1,
        '{14'd1, 4'd1, 5'd1, 1'b0, 1'b0, 23'sd0, 1'b1}},
      '{'{OP_LOAD, 14'd2000, 4'd4, 5'd31, 23'sd0}, 1'b1,
        '{14'd1, 4'd1, 5'd1, 1'b0, 1'b0, 23'sd0, 1'b1}},
      '{'{OP_LOAD, 14'd1900, 4'd2, 5'd29, 23'sd0}, 1'b1,
        '{14'd1, 4'd1, 5'd1, 1'b0, 1'b0, 23'sd0, 1'b1}},
      '{'{OP_LOAD, 14'd2000, 4'd2, 5'd0, 23'sd0}, 1'b1,
        '{14'd1, 4'd1, 5'd1, 1'b0, 1'b0, 23'sd0, 1'b1}},
      // leap day in a year divisible by 400
      '{'{OP_LOAD, 14'd2000, 4'd2, 5'd29, 23'sd0}, 1'b1,
        '{14'd2000, 4'd2, 5'd29, 1'b0, 1'b0, 23'sd0, 1'b0}},
      '{'{OP_COMPARE, 14'd2100, 4'd2, 5'd29, 23'sd0}, 1'b1,
        '{14'd2000, 4'd2, 5'd29, 1'b0, 1'b0, 23'sd0, 1'b1}},
      '{'{OP_ADD, 14'd0, 4'd0, 5'd0, 23'sd1}, 1'b0, '0},
      // widest offsets the port can carry
      '{'{OP_ADD, 14'd0, 4'd0, 5'd0, 23'h3fffff}, 1'b0, '0},
      '{'{OP_ADD, 14'd0, 4'd0, 5'd0, 23'h400000}, 1'b0, '0},
      // year rollover
      '{'{OP_LOAD, 14'd2023, 4'd12, 5'd31, 23'sd0}, 1'b0, '0},
      '{'{OP_ADD, 14'd0, 4'd0, 5'd0, 23'sd1}, 1'b0, '0}
   };

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Offer one request; entered and left at a falling edge. Valid stays high on
   // return so that back-to-back requests need no second assignment in a step.
   task automatic send_op(req_payload_type p, bit typed, rsp_payload_type want);
      rsp_payload_type model_rsp;
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= p.op;
      req_bus.date_year  <= p.date_year;
      req_bus.date_month <= p.date_month;
      req_bus.date_day   <= p.date_day;
      req_bus.day_offset <= p.day_offset;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // transfer done at this edge: advance the model and queue its answer
      model_rsp = apply_date_op(p);
      due_rsp.push_back(typed ? want : model_rsp);
      @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Response side
   // -------------------------------------------------------------------------

   // Drive ready at falling edges; a forced hold-off takes priority over the
   // random stalls.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Check every response transfer against the oldest owed response.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (due_rsp.size() == 0) begin
            $error("response with none owed: %0d-%0d-%0d err %0b", rsp_bus.out_year,
                   rsp_bus.out_month, rsp_bus.out_day, rsp_bus.error);
            fails++;
         end else begin
            want = due_rsp.pop_front();
            if (rsp_bus.out_year !== want.out_year) begin
               $error("out_year: expected %0d, got %0d", want.out_year, rsp_bus.out_year);
               fails++;
            end
            if (rsp_bus.out_month !== want.out_month) begin
               $error("out_month: expected %0d, got %0d", want.out_month,
                      rsp_bus.out_month);
               fails++;
            end
            if (rsp_bus.out_day !== want.out_day) begin
               $error("out_day: expected %0d, got %0d", want.out_day, rsp_bus.out_day);
               fails++;
            end
            if (rsp_bus.is_less !== want.is_less) begin
               $error("is_less: expected %0b, got %0b", want.is_less, rsp_bus.is_less);
               fails++;
            end
            if (rsp_bus.is_equal !== want.is_equal) begin
               $error("is_equal: expected %0b, got %0b", want.is_equal, rsp_bus.is_equal);
               fails++;
            end
            if (rsp_bus.day_difference !== want.day_difference) begin
               $error("day_difference: expected %0d, got %0d", want.day_difference,
                      rsp_bus.day_difference);
               fails++;
            end
            if (rsp_bus.error !== want.error) begin
               $error("error: expected %0b, got %0b", want.error, rsp_bus.error);
               fails++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      // hold every input at a known value from time zero
      req_bus.valid      <= 1'b0;
      req_bus.op         <= OP_LOAD;
      req_bus.date_year  <= '0;
      req_bus.date_month <= '0;
      req_bus.date_day   <= '0;
      req_bus.day_offset <= '0;
      cur_y = YEAR_W'(1);
      cur_m = MONTH_W'(1);
      cur_d = DAY_W'(1);

      // hold reset, then drop it away from the rising edge
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners, no idling on either side
      foreach (dir_rows[i]) send_op(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

      // random phases: a long receiver hold-off then free-running, sender idle, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
               // hold the receiver off for a long stretch so the block backs up
               // and stalls the request side while requests keep coming
               hold_left = 400;
            end
            1: begin
               idle_pct  = 77;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 77;
            end
            default: begin
               idle_pct  = 14;
               stall_pct = 14;
            end
         endcase
         repeat (140) send_op(random_req(), 1'b0, '0);
      end
      req_bus.valid <= 1'b0;

      // drain: wait for every owed response, then watch a while for strays
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      if (fails == 0 && due_rsp.size() == 0) begin
         $display("calendar_date_arithmetic test passed");
      end else begin
         $display("calendar_date_arithmetic test failed");
      end
      $finish;
   end

endmodule
